// ===== rtl/core/mqa_pkg.sv =====
package mqa_pkg;

  // Field widths of the coefficient channels
  localparam int FUNC_W  = 3;
  localparam int OPA_W   = 16;
  localparam int OPB_W   = 14;
  localparam int COEFF_W = 14;
  localparam int MAX_W   = 13;

  // Register stages from the input register to the result register
  localparam int NUM_STAGES = 9;

  // Operation codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_SUB    = 3'd1,
    FUNC_NEG    = 3'd2,
    FUNC_SCALE  = 3'd3,
    FUNC_REDUCE = 3'd4,
    FUNC_NORM   = 3'd5
  } func_e;

  // Stage enables of one Barrett reduction lane
  typedef struct packed {
    logic mul;
    logic mid;
    logic res;
  } barr_en_t;

  // Pipeline control: per-stage load enables and valid flags
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/mqa_if.sv =====
// Input channel: one coefficient operation per transaction
interface mqa_in_if;
  logic                               valid;
  logic                               ready;
  logic [mqa_pkg::FUNC_W-1:0]         func;
  logic signed [mqa_pkg::OPA_W-1:0]   operand_a;
  logic [mqa_pkg::OPB_W-1:0]          operand_b;
  logic                               last;

  modport source (output valid, func, operand_a, operand_b, last, input ready);
  modport sink   (input valid, func, operand_a, operand_b, last, output ready);
endinterface

// Output channel: one result per transaction
interface mqa_out_if;
  logic                               valid;
  logic                               ready;
  logic [mqa_pkg::COEFF_W-1:0]        coeff_out;
  logic [mqa_pkg::MAX_W-1:0]          max_abs;
  logic                               norm_done;

  modport source (output valid, coeff_out, max_abs, norm_done, input ready);
  modport sink   (input valid, coeff_out, max_abs, norm_done, output ready);
endinterface

// ===== rtl/core/mqa_barrett.sv =====
// Three-stage Barrett reduction of an unsigned value below 2**IN_W, mod MODULUS
module mqa_barrett #(
  parameter int IN_W    = 17,
  parameter int MODULUS = 3329
) (
  input  logic                             clk_i,
  input  mqa_pkg::barr_en_t                en_i,
  input  logic [IN_W-1:0]                  x_i,
  output logic [$clog2(MODULUS + 1)-1:0]   res_o
);
  import mqa_pkg::*;

  localparam int    SHIFT = IN_W;
  localparam longint M_VAL = (longint'(1) << SHIFT) / MODULUS;
  localparam int    M_W   = $clog2(M_VAL + 1);
  localparam int    Q_W   = $clog2(MODULUS + 1);
  localparam int    P_W   = IN_W + M_W;
  localparam int    QQ_W  = M_W + Q_W;
  localparam int    R_W   = Q_W + 1;
  localparam int    D_W   = (IN_W > R_W) ? IN_W : R_W;
  localparam logic [M_W-1:0] M_C = M_W'(M_VAL);
  localparam logic [Q_W-1:0] Q_C = Q_W'(MODULUS);

  logic [IN_W-1:0] x_a_q;
  logic [P_W-1:0]  prod_q;
  logic [IN_W-1:0] x_b_q;
  logic [IN_W-1:0] qq_q;
  logic [M_W-1:0]  qest;
  logic [QQ_W-1:0] qq_full;
  logic [D_W-1:0]  diff;
  logic [R_W-1:0]  rem;
  logic [Q_W-1:0]  res_d;
  logic [Q_W-1:0]  res_q;

  // Reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      x_a_q  <= x_i;
      prod_q <= P_W'(x_i) * P_W'(M_C);
    end
  end

  // Quotient estimate times modulus; estimate is low by at most one
  assign qest    = prod_q[P_W-1:SHIFT];
  assign qq_full = QQ_W'(qest) * QQ_W'(Q_C);

  always_ff @(posedge clk_i) begin
    if (en_i.mid) begin
      x_b_q <= x_a_q;
      qq_q  <= qq_full[IN_W-1:0];
    end
  end

  // Remainder lies in 0..2q-1: one conditional subtract
  assign diff  = D_W'(x_b_q) - D_W'(qq_q);
  assign rem   = diff[R_W-1:0];
  assign res_d = (rem >= R_W'(Q_C)) ? Q_W'(rem - R_W'(Q_C)) : rem[Q_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/mqa_pipe_ctrl.sv =====
// Valid flags and per-stage load enables; a stage loads when it is empty
// or its content moves on, so bubbles are squeezed out under back-pressure
module mqa_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output mqa_pkg::pipe_ctl_t  ctl_o
);
  import mqa_pkg::*;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] load;

  // Load chain from the result register backwards
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  // Valid flags follow the data
  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o.load  = load;
  assign ctl_o.valid = valid_q;

endmodule

// ===== rtl/core/mod_q_coefficient_alu_top.sv =====
// Throughput: one transaction per cycle; a result that waits holds only
// the stages behind it, empty stages keep accepting.
// Depth is set by two Barrett reductions in series (operands, then product),
// each three stages, between the input, product and result registers.
// Reset clears all valid flags and the running maximum; data registers are
// not reset.
module mod_q_coefficient_alu_top #(
  parameter int MODULUS = 3329
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mqa_in_if.sink     in_i,
  mqa_out_if.source  out_o
);
  import mqa_pkg::*;

  localparam int Q_W    = $clog2(MODULUS + 1);
  localparam int R_W    = Q_W + 1;
  localparam int P_W    = 2 * Q_W;
  localparam int HALF   = MODULUS / 2;
  localparam int MAG_W  = $clog2(HALF + 1);
  localparam int UA_W   = OPA_W + 1;
  localparam int A_SPAN = 2 ** (OPA_W - 1);
  localparam int A_OFFS = MODULUS * ((A_SPAN + MODULUS - 1) / MODULUS);
  localparam logic [Q_W-1:0] Q_C = Q_W'(MODULUS);

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              last;
  } side_t;

  pipe_ctl_t        ctl;
  barr_en_t         ab_en;
  barr_en_t         p_en;
  side_t            side_q [0:7];
  logic [UA_W-1:0]  ua0_q;
  logic [OPB_W-1:0] b0_q;
  logic [Q_W-1:0]   a_r;
  logic [Q_W-1:0]   b_r;
  logic [Q_W-1:0]   p_r;
  logic [P_W-1:0]   prod4_q;
  logic [Q_W-1:0]   simple_d;
  logic [MAG_W-1:0] mag_d;
  logic [Q_W-1:0]   simple_q [4:7];
  logic [MAG_W-1:0] mag_q [4:7];
  logic [R_W-1:0]   sum;
  logic [Q_W-1:0]   add_v;
  logic [Q_W-1:0]   sub_v;
  logic [Q_W-1:0]   neg_v;
  logic [MAG_W-1:0] running_max_q;
  logic [MAG_W-1:0] running_max_d;
  logic [MAG_W-1:0] maxv;
  logic             done_d;
  logic [Q_W-1:0]   coeff_d;
  logic [Q_W-1:0]   coeff_q;
  logic [MAG_W-1:0] max_q;
  logic             done_q;
  logic             is_norm7;
  logic             fold_w;

  // Pipeline control
  mqa_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  assign in_i.ready = ctl.load[0];

  // Stage 0: input register; a is offset by a multiple of q to be non-negative
  always_ff @(posedge clk_i) begin
    if (ctl.load[0]) begin
      side_q[0] <= '{func: in_i.func, last: in_i.last};
      ua0_q     <= {in_i.operand_a[OPA_W-1], in_i.operand_a} + UA_W'(A_OFFS);
      b0_q      <= in_i.operand_b;
    end
  end

  // Side-band fields travel with the item
  for (genvar k = 1; k < 8; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (ctl.load[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stages 1 to 3: full reduction of both operands
  assign ab_en = '{mul: ctl.load[1], mid: ctl.load[2], res: ctl.load[3]};

  mqa_barrett #(.IN_W(UA_W), .MODULUS(MODULUS)) u_red_a (
    .clk_i (clk_i),
    .en_i  (ab_en),
    .x_i   (ua0_q),
    .res_o (a_r)
  );

  mqa_barrett #(.IN_W(OPB_W), .MODULUS(MODULUS)) u_red_b (
    .clk_i (clk_i),
    .en_i  (ab_en),
    .x_i   (b0_q),
    .res_o (b_r)
  );

  // Stage 4: product, cheap modular ops and centred magnitude
  assign sum   = R_W'(a_r) + R_W'(b_r);
  assign add_v = (sum >= R_W'(Q_C)) ? Q_W'(sum - R_W'(Q_C)) : sum[Q_W-1:0];
  assign sub_v = (a_r >= b_r) ? Q_W'(a_r - b_r)
                              : Q_W'(R_W'(a_r) + R_W'(Q_C) - R_W'(b_r));
  assign neg_v = (a_r == '0) ? '0 : Q_W'(Q_C - a_r);
  assign mag_d = (a_r > Q_W'(HALF)) ? MAG_W'(Q_C - a_r) : MAG_W'(a_r);

  always_comb begin
    case (side_q[3].func)
      FUNC_ADD:    simple_d = add_v;
      FUNC_SUB:    simple_d = sub_v;
      FUNC_NEG:    simple_d = neg_v;
      FUNC_REDUCE: simple_d = a_r;
      default:     simple_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load[4]) begin
      prod4_q     <= P_W'(a_r) * P_W'(b_r);
      simple_q[4] <= simple_d;
      mag_q[4]    <= mag_d;
    end
  end

  for (genvar k = 5; k < 8; k++) begin : g_ops
    always_ff @(posedge clk_i) begin
      if (ctl.load[k]) begin
        simple_q[k] <= simple_q[k-1];
        mag_q[k]    <= mag_q[k-1];
      end
    end
  end

  // Stages 5 to 7: reduction of the product
  assign p_en = '{mul: ctl.load[5], mid: ctl.load[6], res: ctl.load[7]};

  mqa_barrett #(.IN_W(P_W), .MODULUS(MODULUS)) u_red_p (
    .clk_i (clk_i),
    .en_i  (p_en),
    .x_i   (prod4_q),
    .res_o (p_r)
  );

  // Stage 8: result select and running maximum fold
  assign is_norm7 = (side_q[7].func == FUNC_NORM);
  assign fold_w   = ctl.load[8] && ctl.valid[7];

  always_comb begin
    maxv          = running_max_q;
    done_d        = 1'b0;
    running_max_d = running_max_q;
    if (is_norm7) begin
      if (mag_q[7] > running_max_q) begin
        maxv = mag_q[7];
      end
      done_d        = side_q[7].last;
      running_max_d = side_q[7].last ? '0 : maxv;
    end
    coeff_d = (side_q[7].func == FUNC_SCALE) ? p_r : simple_q[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_max_q <= '0;
    end else if (fold_w) begin
      running_max_q <= running_max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load[8]) begin
      coeff_q <= coeff_d;
      max_q   <= maxv;
      done_q  <= done_d;
    end
  end

  assign out_o.valid     = ctl.valid[8];
  assign out_o.coeff_out = COEFF_W'(coeff_q);
  assign out_o.max_abs   = MAX_W'(max_q);
  assign out_o.norm_done = done_q;

  // Checks
  a_max_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_w && is_norm7 && side_q[7].last |=> running_max_q == '0)
    else $error("running maximum not cleared after closing norm item");

  a_max_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_w && !(is_norm7 && side_q[7].last) |=> running_max_q >= $past(running_max_q))
    else $error("running maximum decreased within a polynomial");

  a_coeff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (coeff_q < Q_C) && (max_q <= MAG_W'(HALF)))
    else $error("result out of range");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== bench/mod_q_coefficient_alu_top_test.sv =====
`timescale 1ns / 100ps

module mod_q_coefficient_alu_top_test;
  import mqa_pkg::*;

  localparam int MODULUS     = 3329;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_OPS    = 1250;

  // Func codes the block leaves unused
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [OPA_W-1:0] operand_a;
    logic [OPB_W-1:0]        operand_b;
    logic                    last;
  } coeff_op_t;

  typedef struct {
    logic [COEFF_W-1:0] coeff_out;
    logic [MAX_W-1:0]   max_abs;
    logic               norm_done;
  } coeff_res_t;

  logic clk_i;
  logic rst_ni;

  mqa_in_if  in_if ();
  mqa_out_if out_if ();

  mod_q_coefficient_alu_top #(
    .MODULUS(MODULUS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  coeff_op_t  pending_ops[$];
  coeff_res_t predicted_results[$];
  logic [MAX_W-1:0] peak_mag;
  int sent_cnt;
  int recv_cnt;
  int fail_cnt;
  int cycle_cnt;

  // Exact residue of a signed value, 0..MODULUS-1
  function automatic int residue_of(int x);
    int m;
    if (x >= 0) return x % MODULUS;
    m = (-x) % MODULUS;
    return (m == 0) ? 0 : MODULUS - m;
  endfunction

  // Expected result of one transaction; advances the running peak, clears it on a closing norm item
  function automatic coeff_res_t alu_predict(coeff_op_t op);
    coeff_res_t r;
    int a, b, c, mag, pk;
    a = residue_of(int'($signed(op.operand_a)));
    b = int'(op.operand_b) % MODULUS;
    c = 0;
    r.max_abs   = peak_mag;
    r.norm_done = 1'b0;
    case (op.func)
      FUNC_ADD: begin
        c = a + b;
        if (c >= MODULUS) c -= MODULUS;
      end
      FUNC_SUB:    c = (a >= b) ? a - b : a + MODULUS - b;
      FUNC_NEG:    c = (a == 0) ? 0 : MODULUS - a;
      FUNC_SCALE:  c = (a * b) % MODULUS;
      FUNC_REDUCE: c = a;
      FUNC_NORM: begin
        mag = (a > MODULUS / 2) ? MODULUS - a : a;
        pk  = (mag > int'(peak_mag)) ? mag : int'(peak_mag);
        r.max_abs = pk[MAX_W-1:0];
        if (op.last) begin
          r.norm_done = 1'b1;
          peak_mag    = '0;
        end else begin
          peak_mag = pk[MAX_W-1:0];
        end
      end
      default: c = 0;
    endcase
    r.coeff_out = c[COEFF_W-1:0];
    return r;
  endfunction

  task automatic push_op(logic [FUNC_W-1:0] f, int a, int b, bit lst);
    coeff_op_t op;
    op.func      = f;
    op.operand_a = 16'(a);
    op.operand_b = 14'(b);
    op.last      = lst;
    pending_ops.push_back(op);
  endtask

  // Mostly in-range operand a; full signed range now and then, always for reduce
  function automatic int pick_a(logic [FUNC_W-1:0] f);
    if (f == FUNC_REDUCE || $urandom_range(99) < 15) return int'($urandom_range(16'hFFFF));
    return int'($urandom_range(MODULUS - 1));
  endfunction

  function automatic int pick_b();
    if ($urandom_range(99) < 15) return int'($urandom_range(14'h3FFF));
    return int'($urandom_range(MODULUS - 1));
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stimulus, reset and end of run
  initial begin
    logic [FUNC_W-1:0] f;
    int len;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = '0;
    in_if.operand_a  = '0;
    in_if.operand_b  = '0;
    in_if.last       = 1'b0;
    out_if.ready     = 1'b0;
    peak_mag         = '0;
    sent_cnt         = 0;
    recv_cnt         = 0;
    fail_cnt         = 0;

    // Directed: field extremes, every operation, out-of-range operands
    push_op(FUNC_ADD, 0, 0, 1'b0);
    push_op(FUNC_ADD, MODULUS - 1, MODULUS - 1, 1'b1);   // last ignored outside norm
    push_op(FUNC_ADD, -1, 14'h3FFF, 1'b0);
    push_op(FUNC_SUB, 0, MODULUS - 1, 1'b0);
    push_op(FUNC_SUB, MODULUS - 1, 0, 1'b0);
    push_op(FUNC_SUB, 32767, 14'h3FFF, 1'b0);
    push_op(FUNC_NEG, 0, 0, 1'b0);
    push_op(FUNC_NEG, MODULUS - 1, 14'h3FFF, 1'b0);
    push_op(FUNC_NEG, -32768, 0, 1'b0);
    push_op(FUNC_SCALE, MODULUS - 1, MODULUS - 1, 1'b0);
    push_op(FUNC_SCALE, 0, 14'h3FFF, 1'b0);
    push_op(FUNC_SCALE, -1, 14'h3FFF, 1'b0);
    push_op(FUNC_REDUCE, -32768, 0, 1'b0);
    push_op(FUNC_REDUCE, 32767, 0, 1'b0);
    push_op(FUNC_REDUCE, -1, 0, 1'b0);
    push_op(FUNC_REDUCE, -MODULUS, 0, 1'b0);
    // Centre value stays positive, one past it folds to the negative side
    push_op(FUNC_NORM, MODULUS / 2, 0, 1'b0);
    push_op(FUNC_NORM, MODULUS / 2 + 1, 14'h3FFF, 1'b0);
    push_op(FUNC_NORM, 0, 0, 1'b1);
    push_op(FUNC_NORM, MODULUS - 1, 0, 1'b0);
    push_op(FUNC_NORM, -32768, 0, 1'b1);
    push_op(FUNC_NORM, 32767, 0, 1'b1);
    push_op(FUNC_SPARE_6, 1234, 567, 1'b0);
    push_op(FUNC_SPARE_7, -1, 14'h3FFF, 1'b1);

    // Random: norm polynomials with other operations in between, plus noise
    for (int n = 0; n < RAND_OPS; ) begin
      if ($urandom_range(99) < 35) begin
        len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 15) begin
            f = 3'($urandom_range(FUNC_REDUCE));
            push_op(f, pick_a(f), pick_b(), 1'($urandom_range(1)));
          end else begin
            push_op(FUNC_NORM, pick_a(FUNC_NORM), pick_b(), k == len - 1);
          end
          n++;
        end
      end else begin
        if ($urandom_range(99) < 3) f = $urandom_range(1) ? FUNC_SPARE_7 : FUNC_SPARE_6;
        else f = 3'($urandom_range(FUNC_NORM));
        push_op(f, pick_a(f), pick_b(), 1'($urandom_range(1)));
        n++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_ops.size() == 0 && !in_if.valid);
    wait (predicted_results.size() == 0);
    repeat (4 * NUM_STAGES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: predicts on each accepted transaction, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_ops
    coeff_op_t taken, nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken.func      = in_if.func;
        taken.operand_a = in_if.operand_a;
        taken.operand_b = in_if.operand_b;
        taken.last      = in_if.last;
        predicted_results.push_back(alu_predict(taken));
        sent_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        // no idling on the input side while sent_cnt is in 500..799
        if (pending_ops.size() != 0 &&
            ((sent_cnt >= 500 && sent_cnt < 800) || $urandom_range(99) >= 32)) begin
          nxt = pending_ops.pop_front();
          in_if.valid     <= 1'b1;
          in_if.func      <= nxt.func;
          in_if.operand_a <= nxt.operand_a;
          in_if.operand_b <= nxt.operand_b;
          in_if.last      <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    coeff_res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        recv_cnt++;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result coeff_out=%0d max_abs=%0d norm_done=%0b",
                   $time, out_if.coeff_out, out_if.max_abs, out_if.norm_done);
          fail_cnt++;
        end else begin
          want = predicted_results.pop_front();
          if (out_if.coeff_out !== want.coeff_out) begin
            $display("%0t: coeff_out expected %0d actual %0d",
                     $time, want.coeff_out, out_if.coeff_out);
            fail_cnt++;
          end
          if (out_if.max_abs !== want.max_abs) begin
            $display("%0t: max_abs expected %0d actual %0d",
                     $time, want.max_abs, out_if.max_abs);
            fail_cnt++;
          end
          if (out_if.norm_done !== want.norm_done) begin
            $display("%0t: norm_done expected %0b actual %0b",
                     $time, want.norm_done, out_if.norm_done);
            fail_cnt++;
          end
        end
      end
      // no back-pressure while recv_cnt is in 500..799
      out_if.ready <= (recv_cnt >= 500 && recv_cnt < 800) || ($urandom_range(99) >= 32);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
